// ===== design/gsa_pkg.sv =====
// Shared constants, command codes and request/response types for the aggregation block.
package gsa_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 8192;

    localparam int NODE_W = $clog2(MAX_NODES + 1);
    localparam int EDGE_W = $clog2(MAX_EDGES + 1);
    localparam int LAB_W  = NODE_W + 1;

    localparam logic [2:0] CMD_WPTR  = 3'd0;
    localparam logic [2:0] CMD_WCOL  = 3'd1;
    localparam logic [2:0] CMD_RUN   = 3'd2;
    localparam logic [2:0] CMD_RLAB  = 3'd3;
    localparam logic [2:0] CMD_RROOT = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [12:0] index;
        logic [13:0] value;
    } t_req;

    typedef struct packed {
        logic [10:0] result_value;
        logic [10:0] aggregate_count;
        logic        done_res;
    } t_rsp;

endpackage

// ===== design/gsa_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/gsa_core.sv =====
// Command sequencer that runs the three aggregation passes over the graph memories.
module gsa_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [10:0]    i_node_count,
    input  logic           i_start,
    input  gsa_pkg::t_req  i_req,
    output logic           o_idle,
    output logic           o_rsp_valid,
    output gsa_pkg::t_rsp  o_rsp,
    input  logic           i_rsp_take
);
    import gsa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDLAB  = 4'd1;
    localparam logic [3:0] S_RDROOT = 4'd2;
    localparam logic [3:0] S_RESP   = 4'd3;
    localparam logic [3:0] S_CLR    = 4'd4;
    localparam logic [3:0] S_NODE   = 4'd5;
    localparam logic [3:0] S_NLAB   = 4'd6;
    localparam logic [3:0] S_PTR0   = 4'd7;
    localparam logic [3:0] S_PTR1   = 4'd8;
    localparam logic [3:0] S_PTR2   = 4'd9;
    localparam logic [3:0] S_EDGE   = 4'd10;
    localparam logic [3:0] S_COL    = 4'd11;
    localparam logic [3:0] S_JLAB   = 4'd12;
    localparam logic [3:0] S_LEND   = 4'd13;

    localparam logic [NODE_W-1:0] MAXN     = NODE_W'(MAX_NODES);
    localparam logic [NODE_W-1:0] LAST_N   = NODE_W'(MAX_NODES - 1);
    localparam logic [EDGE_W-1:0] MAXE     = EDGE_W'(MAX_EDGES);
    localparam int                PA_W     = $clog2(MAX_NODES + 1);
    localparam int                CA_W     = $clog2(MAX_EDGES);
    localparam int                LA_W     = $clog2(MAX_NODES);

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_pass, n_pass;
    logic              r_phase, n_phase;
    logic [NODE_W-1:0] r_i, n_i;
    logic [NODE_W-1:0] r_next, n_next;
    logic [EDGE_W-1:0] r_k, n_k;
    logic [EDGE_W-1:0] r_lo, n_lo;
    logic [EDGE_W-1:0] r_hi, n_hi;
    logic [13:0]       r_j, n_j;
    logic              r_any, n_any;
    logic              r_busy, n_busy;
    logic              r_ran, n_ran;
    logic [10:0]       r_res, n_res;
    logic              r_done, n_done;
    logic [10:0]       r_agg, n_agg;

    logic [NODE_W-1:0] w_n;
    logic [LAB_W-1:0]  w_iso;
    logic [EDGE_W-1:0] w_end;
    logic [EDGE_W-1:0] w_ptr_ext;

    logic              ptr_we;
    logic [PA_W-1:0]   ptr_waddr, ptr_raddr;
    logic [13:0]       ptr_wdata, ptr_rdata;
    logic              col_we;
    logic [CA_W-1:0]   col_waddr, col_raddr;
    logic [13:0]       col_wdata, col_rdata;
    logic              lab_we;
    logic [LA_W-1:0]   lab_waddr, lab_raddr;
    logic [LAB_W-1:0]  lab_wdata, lab_rdata;
    logic              root_we;
    logic [LA_W-1:0]   root_waddr, root_raddr;
    logic [9:0]        root_wdata, root_rdata;

    gsa_ram #(.WIDTH(14), .DEPTH(MAX_NODES + 1)) u_ptr (
        .i_clk(i_clk), .i_we(ptr_we), .i_waddr(ptr_waddr), .i_wdata(ptr_wdata),
        .i_raddr(ptr_raddr), .o_rdata(ptr_rdata));
    gsa_ram #(.WIDTH(14), .DEPTH(MAX_EDGES)) u_col (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(col_waddr), .i_wdata(col_wdata),
        .i_raddr(col_raddr), .o_rdata(col_rdata));
    gsa_ram #(.WIDTH(LAB_W), .DEPTH(MAX_NODES)) u_lab (
        .i_clk(i_clk), .i_we(lab_we), .i_waddr(lab_waddr), .i_wdata(lab_wdata),
        .i_raddr(lab_raddr), .o_rdata(lab_rdata));
    gsa_ram #(.WIDTH(10), .DEPTH(MAX_NODES)) u_root (
        .i_clk(i_clk), .i_we(root_we), .i_waddr(root_waddr), .i_wdata(root_wdata),
        .i_raddr(root_raddr), .o_rdata(root_rdata));

    always_comb begin
        if (i_node_count == '0) begin
            w_n = NODE_W'(1);
        end else if (i_node_count > 11'(MAX_NODES)) begin
            w_n = MAXN;
        end else begin
            w_n = NODE_W'(i_node_count);
        end
        w_iso     = -{1'b0, w_n};
        w_ptr_ext = EDGE_W'(ptr_rdata);
        w_end     = (w_ptr_ext > MAXE) ? MAXE : w_ptr_ext;
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_phase = r_phase;
        n_i     = r_i;
        n_next  = r_next;
        n_k     = r_k;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_j     = r_j;
        n_any   = r_any;
        n_busy  = r_busy;
        n_ran   = r_ran;
        n_res   = r_res;
        n_done  = r_done;
        n_agg   = r_agg;

        ptr_we     = 1'b0;
        ptr_waddr  = PA_W'(i_req.index);
        ptr_wdata  = i_req.value;
        ptr_raddr  = PA_W'(r_i);
        col_we     = 1'b0;
        col_waddr  = CA_W'(i_req.index);
        col_wdata  = i_req.value;
        col_raddr  = CA_W'(r_k);
        lab_we     = 1'b0;
        lab_waddr  = LA_W'(r_i);
        lab_wdata  = '0;
        lab_raddr  = LA_W'(r_i);
        root_we    = 1'b0;
        root_waddr = LA_W'(r_next);
        root_wdata = 10'(r_i);
        root_raddr = LA_W'(i_req.index);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res  = '0;
                    n_done = 1'b1;
                    n_state = S_RESP;
                    case (i_req.cmd)
                        CMD_WPTR: begin
                            ptr_we = (i_req.index <= 13'(MAX_NODES));
                        end
                        CMD_WCOL: begin
                            col_we = (14'(i_req.index) < 14'(MAX_EDGES));
                        end
                        CMD_RUN: begin
                            n_i     = '0;
                            n_state = S_CLR;
                        end
                        CMD_RLAB: begin
                            lab_raddr = LA_W'(i_req.index);
                            if (r_ran && (i_req.index < 13'(w_n))) begin
                                n_state = S_RDLAB;
                            end
                        end
                        CMD_RROOT: begin
                            if (i_req.index < 13'(MAX_NODES)) begin
                                n_state = S_RDROOT;
                            end
                        end
                        default: begin
                            n_done = 1'b0;
                        end
                    endcase
                end
            end
            S_RDLAB: begin
                n_res   = lab_rdata[10:0];
                n_state = S_RESP;
            end
            S_RDROOT: begin
                n_res   = {1'b0, root_rdata};
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_rsp_take) begin
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                lab_we    = 1'b1;
                lab_wdata = '0;
                n_i       = r_i + 1'b1;
                if (r_i == LAST_N) begin
                    n_i     = '0;
                    n_pass  = 2'd1;
                    n_phase = 1'b0;
                    n_next  = NODE_W'(1);
                    n_state = S_NODE;
                end
            end
            S_NODE: begin
                if (r_i == w_n) begin
                    n_i = '0;
                    if (r_pass == 2'd1) begin
                        n_pass = 2'd2;
                    end else if (r_pass == 2'd2) begin
                        n_pass = 2'd3;
                        n_next = r_next - 1'b1;
                    end else begin
                        n_agg   = 11'(r_next);
                        n_ran   = 1'b1;
                        n_state = S_RESP;
                    end
                end else begin
                    n_state = S_NLAB;
                end
            end
            S_NLAB: begin
                if (lab_rdata == '0) begin
                    n_state = S_PTR0;
                end else begin
                    if (r_pass == 2'd3) begin
                        lab_we = 1'b1;
                        if (!lab_rdata[LAB_W-1]) begin
                            lab_wdata = lab_rdata - 1'b1;
                        end else if (lab_rdata == w_iso) begin
                            lab_wdata = '1;
                        end else begin
                            lab_wdata = -lab_rdata - 1'b1;
                        end
                    end
                    n_i     = r_i + 1'b1;
                    n_state = S_NODE;
                end
            end
            S_PTR0: begin
                n_state = S_PTR1;
            end
            S_PTR1: begin
                n_lo      = EDGE_W'(ptr_rdata);
                ptr_raddr = PA_W'(r_i + 1'b1);
                n_state   = S_PTR2;
            end
            S_PTR2: begin
                n_hi    = w_end;
                n_lo    = (r_lo >= w_end) ? w_end : r_lo;
                n_k     = (r_lo >= w_end) ? w_end : r_lo;
                n_any   = 1'b0;
                n_busy  = 1'b0;
                n_phase = 1'b0;
                if (r_pass == 2'd3) begin
                    lab_we    = 1'b1;
                    lab_wdata = LAB_W'(r_next);
                    root_we   = (r_next < MAXN);
                end
                n_state = S_EDGE;
            end
            S_EDGE: begin
                if (r_k >= r_hi) begin
                    n_state = S_LEND;
                end else begin
                    n_state = S_COL;
                end
            end
            S_COL: begin
                n_j       = col_rdata;
                lab_raddr = LA_W'(col_rdata);
                lab_waddr = LA_W'(col_rdata);
                if (col_rdata >= 14'(w_n)) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_EDGE;
                end else if (r_pass == 2'd1 && r_phase) begin
                    lab_we    = 1'b1;
                    lab_wdata = LAB_W'(r_next);
                    n_k       = r_k + 1'b1;
                    n_state   = S_EDGE;
                end else if (r_pass == 2'd1 && col_rdata == 14'(r_i)) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_EDGE;
                end else begin
                    if (r_pass == 2'd1) begin
                        n_any = 1'b1;
                    end
                    n_state = S_JLAB;
                end
            end
            S_JLAB: begin
                n_k     = r_k + 1'b1;
                n_state = S_EDGE;
                if (r_pass == 2'd1) begin
                    if (lab_rdata != '0) begin
                        n_busy  = 1'b1;
                        n_state = S_LEND;
                    end
                end else if (r_pass == 2'd2) begin
                    if (!lab_rdata[LAB_W-1] && lab_rdata != '0) begin
                        lab_we    = 1'b1;
                        lab_wdata = -lab_rdata;
                        n_state   = S_LEND;
                    end
                end else begin
                    if (lab_rdata == '0) begin
                        lab_we    = 1'b1;
                        lab_waddr = LA_W'(r_j);
                        lab_wdata = LAB_W'(r_next);
                    end
                end
            end
            S_LEND: begin
                n_i     = r_i + 1'b1;
                n_state = S_NODE;
                if (r_pass == 2'd1) begin
                    if (r_phase) begin
                        n_next  = r_next + 1'b1;
                        n_phase = 1'b0;
                    end else if (!r_any) begin
                        lab_we    = 1'b1;
                        lab_wdata = w_iso;
                    end else if (!r_busy) begin
                        lab_we     = 1'b1;
                        lab_wdata  = LAB_W'(r_next);
                        root_we    = 1'b1;
                        root_waddr = LA_W'(r_next - 1'b1);
                        n_phase    = 1'b1;
                        n_k        = r_lo;
                        n_i        = r_i;
                        n_state    = S_EDGE;
                    end
                end else if (r_pass == 2'd3) begin
                    n_next = r_next + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= '0;
            r_phase <= 1'b0;
            r_ran   <= 1'b0;
            r_agg   <= '0;
            r_res   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_phase <= n_phase;
            r_ran   <= n_ran;
            r_agg   <= n_agg;
            r_res   <= n_res;
            r_done  <= n_done;
        end
        r_i    <= n_i;
        r_next <= n_next;
        r_k    <= n_k;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_j    <= n_j;
        r_any  <= n_any;
        r_busy <= n_busy;
    end

    assign o_idle                = (r_state == S_IDLE);
    assign o_rsp_valid           = (r_state == S_RESP);
    assign o_rsp.result_value    = r_res;
    assign o_rsp.aggregate_count = r_agg;
    assign o_rsp.done_res        = r_done;

    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |-> (r_k <= r_hi))
        else $error("edge cursor passed the row end");
    a_clr_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |=> (r_state == S_CLR || r_state == S_NODE))
        else $error("label clear left early");
    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NLAB) |-> (r_i < w_n))
        else $error("node cursor beyond node count");
endmodule

// ===== design/graph_standard_aggregation_unit.sv =====
// Top level: request and result handshakes, node count register and the aggregation sequencer.
// Only one request is in work at a time: a write passes the response state, a read a read state
// and then the response state, and the next request is taken once its result has been taken.
// A run clears all MAX_NODES labels, then per pass skips labeled nodes after a label read, reads
// the row ends of each open node and walks its neighbors, and a pass-one root walks its row again.
// Synchronous active-low reset sets the node count to 1, the aggregate count to 0, and makes
// label reads return 0 until the first run; the graph memories are not cleared by reset.
module graph_standard_aggregation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [12:0] i_index,
    input  logic [13:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [10:0] o_result_value,
    output logic [10:0] o_aggregate_count,
    output logic        o_done_res
);
    import gsa_pkg::*;

    logic [10:0] r_node_count;
    logic        r_out_valid;
    t_rsp        r_out;
    t_req        req;
    t_rsp        rsp;
    logic        core_idle;
    logic        rsp_valid;
    logic        rsp_take;

    assign req.cmd   = i_cmd;
    assign req.index = i_index;
    assign req.value = i_value;

    assign o_in_ready = core_idle;
    assign rsp_take   = rsp_valid && (!r_out_valid || i_out_ready);

    gsa_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (r_node_count),
        .i_start      (i_in_valid && core_idle),
        .i_req        (req),
        .o_idle       (core_idle),
        .o_rsp_valid  (rsp_valid),
        .o_rsp        (rsp),
        .i_rsp_take   (rsp_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 11'd1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if (rsp_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (rsp_take) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_value    = r_out.result_value;
    assign o_aggregate_count = r_out.aggregate_count;
    assign o_done_res        = r_out.done_res;
endmodule

// ===== dv/gsa_result_checker.sv =====
// Request/result monitor with a predictor of the aggregation block and a field-by-field compare.
module gsa_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [12:0] i_index,
    input  logic [13:0] i_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [10:0] i_result_value,
    input  logic [10:0] i_aggregate_count,
    input  logic        i_done_res,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_roots_known
);
    import gsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    int unsigned node_cfg;
    int unsigned row_start_mem [0:MAX_NODES];
    int unsigned neighbour_mem [0:MAX_EDGES-1];
    int          node_label    [0:MAX_NODES-1];
    int unsigned agg_root      [0:MAX_NODES-1];
    int unsigned agg_total;
    t_rsp        pending_answers [$];

    initial begin
        node_cfg = 1;
        agg_total = 0;
        o_fail_count = 0;
        o_pending = 0;
        o_roots_known = 0;
        foreach (row_start_mem[i]) row_start_mem[i] = 0;
        foreach (neighbour_mem[i]) neighbour_mem[i] = 0;
        foreach (node_label[i]) node_label[i] = 0;
        foreach (agg_root[i]) agg_root[i] = 0;
    end

    function automatic int unsigned active_nodes();
        if (node_cfg == 0) return 1;
        if (node_cfg > MAX_NODES) return MAX_NODES;
        return node_cfg;
    endfunction

    function automatic void row_span(input int unsigned row, output int unsigned lo,
                                     output int unsigned hi);
        lo = row_start_mem[row];
        hi = row_start_mem[row+1];
        if (hi > MAX_EDGES) hi = MAX_EDGES;
        if (lo >= hi) lo = hi;
    endfunction

    function automatic void aggregate_graph();
        int unsigned n, lo, hi, j;
        int          isolated, next_agg, v;
        bit          busy, any;
        n = active_nodes();
        isolated = -int'(n);
        next_agg = 1;
        foreach (node_label[i]) node_label[i] = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if (node_label[i] != 0) continue;
            busy = 0;
            any = 0;
            row_span(i, lo, hi);
            for (int unsigned k = lo; k < hi; k++) begin
                j = neighbour_mem[k];
                if (j >= n || j == i) continue;
                any = 1;
                if (node_label[j] != 0) begin
                    busy = 1;
                    break;
                end
            end
            if (!any) begin
                node_label[i] = isolated;
            end else if (!busy) begin
                node_label[i] = next_agg;
                agg_root[next_agg-1] = i;
                for (int unsigned k = lo; k < hi; k++) begin
                    j = neighbour_mem[k];
                    if (j < n) node_label[j] = next_agg;
                end
                next_agg++;
            end
        end
        for (int unsigned i = 0; i < n; i++) begin
            if (node_label[i] != 0) continue;
            row_span(i, lo, hi);
            for (int unsigned k = lo; k < hi; k++) begin
                j = neighbour_mem[k];
                if (j >= n) continue;
                if (node_label[j] > 0) begin
                    node_label[i] = -node_label[j];
                    break;
                end
            end
        end
        next_agg--;
        for (int unsigned i = 0; i < n; i++) begin
            v = node_label[i];
            if (v != 0) begin
                if (v > 0) node_label[i] = v - 1;
                else if (v == isolated) node_label[i] = -1;
                else node_label[i] = -v - 1;
                continue;
            end
            row_span(i, lo, hi);
            node_label[i] = next_agg;
            if (next_agg < MAX_NODES) agg_root[next_agg] = i;
            for (int unsigned k = lo; k < hi; k++) begin
                j = neighbour_mem[k];
                if (j < n && node_label[j] == 0) node_label[j] = next_agg;
            end
            next_agg++;
        end
        agg_total = next_agg;
        if (agg_total > MAX_NODES && o_roots_known < MAX_NODES) o_roots_known = MAX_NODES;
        else if (int'(agg_total) > o_roots_known) o_roots_known = agg_total;
    endfunction

    function automatic t_rsp predict_answer(input logic [2:0] c, input logic [12:0] idx,
                                            input logic [13:0] val);
        t_rsp ans;
        int   res;
        res = 0;
        ans.done_res = 1'b1;
        case (c)
            CMD_WPTR:  if (idx <= MAX_NODES) row_start_mem[idx] = val;
            CMD_WCOL:  if (idx < MAX_EDGES) neighbour_mem[idx] = val;
            CMD_RUN:   aggregate_graph();
            CMD_RLAB:  if (idx < active_nodes()) res = node_label[idx];
            CMD_RROOT: if (idx < MAX_NODES) res = agg_root[idx];
            default:   ans.done_res = 1'b0;
        endcase
        ans.result_value = res[10:0];
        ans.aggregate_count = agg_total[10:0];
        return ans;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            node_cfg = 1;
            agg_total = 0;
            foreach (node_label[i]) node_label[i] = 0;
            pending_answers.delete();
        end else begin
            if (i_cfg_we) node_cfg = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: result with no request waiting", $realtime);
                    o_fail_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (i_result_value !== want.result_value)
                        report_mismatch("result_value", i_result_value, want.result_value);
                    if (i_aggregate_count !== want.aggregate_count)
                        report_mismatch("aggregate_count", i_aggregate_count,
                                        want.aggregate_count);
                    if (i_done_res !== want.done_res)
                        report_mismatch("done_res", i_done_res, want.done_res);
                end
            end
            if (i_in_valid && i_in_ready)
                pending_answers.push_back(predict_answer(i_cmd, i_index, i_value));
        end
        o_pending = pending_answers.size();
    end

endmodule

// ===== dv/tb_graph_standard_aggregation_unit.sv =====
// Testbench top: clock, reset, request and result drivers, and the final verdict.
module tb_graph_standard_aggregation_unit;
    import gsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        o_in_ready;
    logic [2:0]  cmd;
    logic [12:0] index;
    logic [13:0] value;
    logic        o_out_valid;
    logic        out_ready;
    logic [10:0] o_result_value;
    logic [10:0] o_aggregate_count;
    logic        o_done_res;

    int fail_count;
    int pending;
    int roots_known;
    int known_roots;
    int max_gap;
    int sent;
    bit hold_results;

    graph_standard_aggregation_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (cmd),
        .i_index          (index),
        .i_value          (value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_result_value   (o_result_value),
        .o_aggregate_count(o_aggregate_count),
        .o_done_res       (o_done_res)
    );

    gsa_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (o_in_ready),
        .i_cmd            (cmd),
        .i_index          (index),
        .i_value          (value),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .i_result_value   (o_result_value),
        .i_aggregate_count(o_aggregate_count),
        .i_done_res       (o_done_res),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_roots_known    (roots_known)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int stall;
        out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3);
            if (hold_results) begin
                stall = 300;
                hold_results = 0;
            end
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && out_ready));
        end
    end

    task automatic send_request(input logic [2:0] c, input logic [12:0] idx,
                                input logic [13:0] val);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        index <= idx;
        value <= val;
        do @(posedge i_clk); while (!(in_valid && o_in_ready));
        sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        known_roots = roots_known;
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_node_count(input logic [10:0] n);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= n;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic read_back(input int n);
        wait_idle();
        for (int i = 0; i <= n; i++) send_request(CMD_RLAB, i, $urandom);
        repeat (4) if (known_roots > 0)
            send_request(CMD_RROOT, $urandom_range(0, known_roots - 1), $urandom);
        send_request(CMD_RROOT, $urandom_range(MAX_NODES, 8191), $urandom);
        send_request(CMD_RLAB, $urandom_range(n + 1, 8191), $urandom);
        send_request($urandom_range(5, 7), $urandom, $urandom);
    endtask

    task automatic random_graph(input bit held);
        int          n, row_pos, edge_lo, edge_hi, deg;
        logic [13:0] nb;
        n = $urandom_range(2, 12);
        set_node_count(n);
        max_gap = $urandom_range(0, 1) ? 3 : 0;
        row_pos = $urandom_range(0, 8100);
        edge_lo = row_pos;
        edge_hi = row_pos;
        for (int i = 0; i <= n; i++) begin
            send_request(CMD_WPTR, i, row_pos);
            if (row_pos > edge_hi) edge_hi = row_pos;
            if (row_pos < edge_lo) edge_lo = row_pos;
            deg = $urandom_range(0, 9) == 0 ? -2 : $urandom_range(0, 4);
            row_pos = row_pos + deg < 0 ? 0 : row_pos + deg;
        end
        for (int k = edge_lo; k < edge_hi && k < MAX_EDGES; k++) begin
            case ($urandom_range(0, 9))
                0:       nb = $urandom_range(n, 16383);
                1:       nb = $urandom_range(0, n - 1) + 0;
                default: nb = $urandom_range(0, n - 1);
            endcase
            send_request(CMD_WCOL, k, nb);
        end
        send_request(CMD_RUN, $urandom, $urandom);
        if (held) begin
            wait_idle();
            hold_results = 1;
            max_gap = 0;
        end
        read_back(n);
        max_gap = 3;
    endtask

    initial begin
        int first_random;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_WPTR;
        index = '0;
        value = '0;
        max_gap = 3;
        sent = 0;
        hold_results = 0;
        known_roots = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_RLAB, 0, 14'h3FFF);
        send_request(CMD_RROOT, 8191, 0);
        send_request(3'd5, 8191, 14'h3FFF);
        send_request(3'd6, 0, 0);
        send_request(3'd7, 13'h1555, 14'h2AAA);
        send_request(CMD_WPTR, 8191, 14'h3FFF);
        send_request(CMD_WPTR, MAX_NODES + 1, 14'h2000);

        send_request(CMD_WPTR, 0, 0);
        send_request(CMD_WPTR, 1, 0);
        set_node_count(0);
        send_request(CMD_RUN, 0, 0);
        read_back(1);
        set_node_count(11'h7FF);
        send_request(CMD_RLAB, MAX_NODES - 1, 0);
        send_request(CMD_RLAB, MAX_NODES, 0);

        set_node_count(2);
        send_request(CMD_WPTR, 0, 8190);
        send_request(CMD_WPTR, 1, 14'h3FFF);
        send_request(CMD_WPTR, 2, 0);
        send_request(CMD_WCOL, 8190, 1);
        send_request(CMD_WCOL, 8191, 0);
        send_request(CMD_RUN, 0, 0);
        read_back(2);

        first_random = sent;
        random_graph(1'b1);
        while (sent - first_random < 60) random_graph(1'b0);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
